// ===== rtl/mcc_pkg.sv =====
package mcc_pkg;

    // Longest pattern collected in decode mode
    localparam int MAX_SYMBOLS = 6;
    localparam int PAT_LEN_W   = $clog2(MAX_SYMBOLS + 1);

    // Longest code in the character table
    localparam int CODE_W      = 6;
    localparam int CODE_LEN_W  = $clog2(CODE_W + 1);
    localparam int NUM_CODES   = 50;

    // ASCII codes used by the codec
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ERR     = 8'h00;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_FOLD  = 8'h20;

    // One table entry: symbols right-aligned, first symbol most significant, dash = 1
    typedef struct packed {
        logic [7:0]            ch;
        logic [CODE_LEN_W-1:0] len;
        logic [CODE_W-1:0]     bits;
    } code_t;

    localparam code_t CODE_TABLE [NUM_CODES] = '{
        '{8'h41, 3'd2, 6'b000001}, // A
        '{8'h42, 3'd4, 6'b001000}, // B
        '{8'h43, 3'd4, 6'b001010}, // C
        '{8'h44, 3'd3, 6'b000100}, // D
        '{8'h45, 3'd1, 6'b000000}, // E
        '{8'h46, 3'd4, 6'b000010}, // F
        '{8'h47, 3'd3, 6'b000110}, // G
        '{8'h48, 3'd4, 6'b000000}, // H
        '{8'h49, 3'd2, 6'b000000}, // I
        '{8'h4A, 3'd4, 6'b000111}, // J
        '{8'h4B, 3'd3, 6'b000101}, // K
        '{8'h4C, 3'd4, 6'b000100}, // L
        '{8'h4D, 3'd2, 6'b000011}, // M
        '{8'h4E, 3'd2, 6'b000010}, // N
        '{8'h4F, 3'd3, 6'b000111}, // O
        '{8'h50, 3'd4, 6'b000110}, // P
        '{8'h51, 3'd4, 6'b001101}, // Q
        '{8'h52, 3'd3, 6'b000010}, // R
        '{8'h53, 3'd3, 6'b000000}, // S
        '{8'h54, 3'd1, 6'b000001}, // T
        '{8'h55, 3'd3, 6'b000001}, // U
        '{8'h56, 3'd4, 6'b000001}, // V
        '{8'h57, 3'd3, 6'b000011}, // W
        '{8'h58, 3'd4, 6'b001001}, // X
        '{8'h59, 3'd4, 6'b001011}, // Y
        '{8'h5A, 3'd4, 6'b001100}, // Z
        '{8'h30, 3'd5, 6'b011111}, // 0
        '{8'h31, 3'd5, 6'b001111}, // 1
        '{8'h32, 3'd5, 6'b000111}, // 2
        '{8'h33, 3'd5, 6'b000011}, // 3
        '{8'h34, 3'd5, 6'b000001}, // 4
        '{8'h35, 3'd5, 6'b000000}, // 5
        '{8'h36, 3'd5, 6'b010000}, // 6
        '{8'h37, 3'd5, 6'b011000}, // 7
        '{8'h38, 3'd5, 6'b011100}, // 8
        '{8'h39, 3'd5, 6'b011110}, // 9
        '{8'h26, 3'd5, 6'b001000}, // ampersand
        '{8'h27, 3'd6, 6'b011110}, // apostrophe
        '{8'h40, 3'd6, 6'b011010}, // at sign
        '{8'h29, 3'd6, 6'b101101}, // close paren
        '{8'h28, 3'd5, 6'b010110}, // open paren
        '{8'h3A, 3'd6, 6'b111000}, // colon
        '{8'h2C, 3'd6, 6'b110011}, // comma
        '{8'h3D, 3'd5, 6'b010001}, // equals
        '{8'h21, 3'd6, 6'b101011}, // exclamation
        '{8'h2E, 3'd6, 6'b010101}, // full stop
        '{8'h2D, 3'd6, 6'b100001}, // hyphen
        '{8'h2B, 3'd5, 6'b001010}, // plus
        '{8'h3F, 3'd6, 6'b001100}, // question mark
        '{8'h2F, 3'd5, 6'b010010}  // slash
    };

    // Results still owed for one input beat: a symbol run, then a head item, then a tail item
    typedef struct packed {
        logic [CODE_W-1:0]     sym_bits;  // left-aligned, next symbol in the top bit
        logic [CODE_LEN_W-1:0] sym_len;
        logic                  head_vld;
        logic [7:0]            head_char;
        logic                  head_err;
        logic                  tail_vld;
        logic [7:0]            tail_char;
        logic                  tail_err;
    } job_t;

endpackage

// ===== rtl/morse_code_codec.sv =====
// Channel  | Direction | Beat contents
// s_       | in        | tdata[7:0] in_char, tlast in_last
// m_       | out       | tdata[7:0] out_char, tuser error_flag, tlast run_end
// cfg_     | in        | cfg_wdata decode_mode, written when cfg_we is high
//
// One result beat leaves per cycle while m_tready is high. An input beat has up to 7
// results in encode mode (code length plus the separator), 1 or 2 for a closing beat in
// decode mode and none for a symbol that only extends the pattern. The next input beat is
// taken in the cycle the last result of the current one moves out.
// Reset (aresetn low, synchronous) selects encode mode and clears the pattern.
// m_tready low holds the result register; the held job and s_tready wait on it.
module morse_code_codec
    import mcc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,    // decode_mode
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,      // [7:0] in_char
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,      // [7:0] out_char
    output logic       m_tuser,      // [0] error_flag
    output logic       m_tlast
);

    job_t job;
    logic in_accept;

    assign in_accept = s_tvalid && s_tready;

    mcc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_accept (in_accept),
        .in_char   (s_tdata),
        .in_last   (s_tlast),
        .job       (job)
    );

    mcc_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .job_in    (job),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_err   (m_tuser),
        .out_end   (m_tlast)
    );

endmodule

// ===== rtl/mcc_front.sv =====
module mcc_front
    import mcc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_accept,
    input  logic [7:0] in_char,
    input  logic       in_last,
    output job_t       job
);

    logic                   decode_mode_reg;
    logic [MAX_SYMBOLS-1:0] pat_bits_reg, pat_bits_next;
    logic [PAT_LEN_W-1:0]   pat_len_reg, pat_len_next;
    logic                   pat_inv_reg, pat_inv_next;
    logic                   pat_slash_reg, pat_slash_next;

    // Map a closed pattern to its character; bit 8 set when it has one
    function automatic logic [8:0] close_lookup(
        input logic                   inv,
        input logic                   slash,
        input logic [PAT_LEN_W-1:0]   len,
        input logic [MAX_SYMBOLS-1:0] bits
    );
        logic       hit;
        logic [7:0] ch;
        hit = 1'b0;
        ch  = CH_ERR;
        for (int i = 0; i < NUM_CODES; i++) begin
            if (!hit && 32'(CODE_TABLE[i].len) == 32'(len)
                     && 32'(CODE_TABLE[i].bits) == 32'(bits)) begin
                hit = 1'b1;
                ch  = CODE_TABLE[i].ch;
            end
        end
        priority if (inv) begin
            return {1'b0, CH_ERR};
        end else if (slash) begin
            return {1'b1, CH_SPACE};
        end else if (len == '0) begin
            return {1'b0, CH_ERR};
        end else begin
            return {hit, ch};
        end
    endfunction

    logic [7:0]            folded;
    logic                  enc_hit;
    logic [CODE_LEN_W-1:0] enc_len;
    logic [CODE_W-1:0]     enc_bits;
    logic [8:0]            close_res;
    logic                  is_sym;

    always_comb begin
        // Fold lower case, then find the character's code
        folded = in_char;
        if (in_char >= CH_LOWER_A && in_char <= CH_LOWER_Z) begin
            folded = in_char - CASE_FOLD;
        end
        enc_hit  = 1'b0;
        enc_len  = '0;
        enc_bits = '0;
        for (int i = 0; i < NUM_CODES; i++) begin
            if (!enc_hit && CODE_TABLE[i].ch == folded) begin
                enc_hit  = 1'b1;
                enc_len  = CODE_TABLE[i].len;
                enc_bits = CODE_TABLE[i].bits;
            end
        end

        job            = '0;
        pat_bits_next  = pat_bits_reg;
        pat_len_next   = pat_len_reg;
        pat_inv_next   = pat_inv_reg;
        pat_slash_next = pat_slash_reg;
        close_res      = '0;
        is_sym         = (in_char == CH_DOT) || (in_char == CH_DASH);

        if (!decode_mode_reg) begin
            // Encode: symbol run, slash or error item, then the separator unless the beat is last
            priority if (in_char == CH_SPACE) begin
                job.head_vld  = 1'b1;
                job.head_char = CH_SLASH;
            end else if (enc_hit) begin
                job.sym_len  = enc_len;
                job.sym_bits = enc_bits << (CODE_LEN_W'(CODE_W) - enc_len);
            end else begin
                job.head_vld  = 1'b1;
                job.head_char = CH_ERR;
                job.head_err  = 1'b1;
            end
            job.tail_vld  = !in_last;
            job.tail_char = CH_SPACE;
        end else if (in_char == CH_SPACE) begin
            // Close the open pattern; a last space also closes the empty one
            close_res      = close_lookup(pat_inv_reg, pat_slash_reg, pat_len_reg,
                                          pat_bits_reg);
            job.head_vld   = 1'b1;
            job.head_char  = close_res[7:0];
            job.head_err   = !close_res[8];
            job.tail_vld   = in_last;
            job.tail_char  = CH_ERR;
            job.tail_err   = 1'b1;
            pat_bits_next  = '0;
            pat_len_next   = '0;
            pat_inv_next   = 1'b0;
            pat_slash_next = 1'b0;
        end else begin
            // Add the symbol to the pattern
            if (!pat_inv_reg) begin
                priority if (is_sym) begin
                    if (pat_slash_reg || pat_len_reg >= PAT_LEN_W'(MAX_SYMBOLS)) begin
                        pat_inv_next = 1'b1;
                    end else begin
                        pat_bits_next = {pat_bits_reg[MAX_SYMBOLS-2:0],
                                         in_char == CH_DASH};
                        pat_len_next  = pat_len_reg + PAT_LEN_W'(1);
                    end
                end else if (in_char == CH_SLASH) begin
                    if (pat_len_reg != '0 || pat_slash_reg) begin
                        pat_inv_next = 1'b1;
                    end else begin
                        pat_slash_next = 1'b1;
                    end
                end else begin
                    pat_inv_next = 1'b1;
                end
            end
            // Last beat closes the updated pattern
            if (in_last) begin
                close_res      = close_lookup(pat_inv_next, pat_slash_next, pat_len_next,
                                              pat_bits_next);
                job.head_vld   = 1'b1;
                job.head_char  = close_res[7:0];
                job.head_err   = !close_res[8];
                pat_bits_next  = '0;
                pat_len_next   = '0;
                pat_inv_next   = 1'b0;
                pat_slash_next = 1'b0;
            end
        end
    end

    // Hold mode and pattern state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decode_mode_reg <= 1'b0;
            pat_bits_reg    <= '0;
            pat_len_reg     <= '0;
            pat_inv_reg     <= 1'b0;
            pat_slash_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                decode_mode_reg <= cfg_wdata;
            end
            if (in_accept) begin
                pat_bits_reg  <= pat_bits_next;
                pat_len_reg   <= pat_len_next;
                pat_inv_reg   <= pat_inv_next;
                pat_slash_reg <= pat_slash_next;
            end
        end
    end

endmodule

// ===== rtl/mcc_emit.sv =====
module mcc_emit
    import mcc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_accept,
    input  job_t       job_in,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       out_err,
    output logic       out_end
);

    job_t       job_reg, job_next, job_used;
    logic       out_vld_reg;
    logic [7:0] out_char_reg;
    logic       out_err_reg;
    logic       out_end_reg;

    logic       pending;
    logic       advance;
    logic       take;
    logic [7:0] item_char;
    logic       item_err;
    logic       item_last;

    // Pick the next item of the held job
    always_comb begin
        pending   = (job_reg.sym_len != '0) || job_reg.head_vld || job_reg.tail_vld;
        job_used  = job_reg;
        item_char = job_reg.tail_char;
        item_err  = job_reg.tail_err;
        item_last = 1'b1;
        priority if (job_reg.sym_len != '0) begin
            item_char         = job_reg.sym_bits[CODE_W-1] ? CH_DASH : CH_DOT;
            item_err          = 1'b0;
            item_last         = (job_reg.sym_len == CODE_LEN_W'(1))
                                && !job_reg.head_vld && !job_reg.tail_vld;
            job_used.sym_bits = job_reg.sym_bits << 1;
            job_used.sym_len  = job_reg.sym_len - CODE_LEN_W'(1);
        end else if (job_reg.head_vld) begin
            item_char         = job_reg.head_char;
            item_err          = job_reg.head_err;
            item_last         = !job_reg.tail_vld;
            job_used.head_vld = 1'b0;
        end else begin
            job_used.tail_vld = 1'b0;
        end

        advance  = !out_vld_reg || out_ready;
        take     = pending && advance;
        in_ready = !pending || (take && item_last);

        job_next = job_reg;
        if (in_accept) begin
            job_next = job_in;
        end else if (take) begin
            job_next = job_used;
        end
    end

    // Advance the job and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            job_reg <= job_next;
            if (advance) begin
                out_vld_reg <= take;
            end
        end
    end

    // Load the result beat
    always_ff @(posedge aclk) begin
        if (take) begin
            out_char_reg <= item_char;
            out_err_reg  <= item_err;
            out_end_reg  <= item_last;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_char  = out_char_reg;
    assign out_err   = out_err_reg;
    assign out_end   = out_end_reg;

endmodule

// ===== tb/tb_morse_code_codec.sv =====
module tb_morse_code_codec
    import mcc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_PERCENT  = 13;

    // One result beat as the block should present it
    typedef struct packed {
        logic [7:0] ch;
        logic       err;
        logic       fin;
    } morse_beat_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;       // [7:0] in_char
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;       // [7:0] out_char
    logic       m_tuser;       // [0] error_flag
    logic       m_tlast;

    // Codec state as predicted
    logic                   decode_mode_q;
    logic [MAX_SYMBOLS-1:0] pat_bits;
    logic [PAT_LEN_W-1:0]   pat_len;
    logic                   pat_bad;
    logic                   pat_slash;

    morse_beat_t owed_beats[$];
    morse_beat_t want;
    int          mismatch_count = 0;
    int          beats_sent;
    int          cycle_count = 0;
    logic        steady;

    morse_code_codec u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Symbols of one upper-case character, empty when it has none
    function automatic string morse_of(input logic [7:0] c);
        case (c)
            "A": return ".-";    "B": return "-...";  "C": return "-.-.";  "D": return "-..";
            "E": return ".";     "F": return "..-.";  "G": return "--.";   "H": return "....";
            "I": return "..";    "J": return ".---";  "K": return "-.-";   "L": return ".-..";
            "M": return "--";    "N": return "-.";    "O": return "---";   "P": return ".--.";
            "Q": return "--.-";  "R": return ".-.";   "S": return "...";   "T": return "-";
            "U": return "..-";   "V": return "...-";  "W": return ".--";   "X": return "-..-";
            "Y": return "-.--";  "Z": return "--..";
            "0": return "-----"; "1": return ".----"; "2": return "..---"; "3": return "...--";
            "4": return "....-"; "5": return "....."; "6": return "-...."; "7": return "--...";
            "8": return "---.."; "9": return "----.";
            "&": return ".-...";  "'": return ".----."; "@": return ".--.-."; ")": return "-.--.-";
            "(": return "-.--.";  ":": return "---..."; ",": return "--..--"; "=": return "-...-";
            "!": return "-.-.--"; ".": return ".-.-.-"; "-": return "-....-"; "+": return ".-.-.";
            "?": return "..--.."; "/": return "-..-.";
            default: return "";
        endcase
    endfunction

    function automatic void owe(input logic [7:0] ch, input logic err);
        morse_beat_t b;
        b.ch  = ch;
        b.err = err;
        b.fin = 1'b0;
        owed_beats.push_back(b);
    endfunction

    // Close the open pattern: decoded character or an error beat, then clear
    function automatic void close_pattern();
        string                  code;
        logic [MAX_SYMBOLS-1:0] cb;
        logic [7:0]             ch;
        logic                   found;
        found = 1'b0;
        ch    = CH_ERR;
        if (!pat_bad && pat_slash) begin
            found = 1'b1;
            ch    = CH_SPACE;
        end else if (!pat_bad && pat_len != 0) begin
            for (int k = 0; k < 256; k++) begin
                code = morse_of(k[7:0]);
                cb   = '0;
                for (int j = 0; j < code.len(); j++)
                    cb = (cb << 1) | (code[j] == CH_DASH);
                if (!found && code.len() == pat_len && cb == pat_bits) begin
                    found = 1'b1;
                    ch    = k[7:0];
                end
            end
        end
        owe(found ? ch : CH_ERR, !found);
        pat_bits  = '0;
        pat_len   = '0;
        pat_bad   = 1'b0;
        pat_slash = 1'b0;
    endfunction

    // Extend the open pattern; anything out of place spoils it
    function automatic void add_symbol(input logic [7:0] c);
        if (!pat_bad) begin
            if (c == CH_DOT || c == CH_DASH) begin
                if (pat_slash || pat_len >= MAX_SYMBOLS) begin
                    pat_bad = 1'b1;
                end else begin
                    pat_bits = (pat_bits << 1) | (c == CH_DASH);
                    pat_len  = pat_len + 1'b1;
                end
            end else if (c == CH_SLASH) begin
                if (pat_len != 0 || pat_slash)
                    pat_bad = 1'b1;
                else
                    pat_slash = 1'b1;
            end else begin
                pat_bad = 1'b1;
            end
        end
    endfunction

    // Work out the result beats owed for one accepted input beat
    function automatic void predict_results(input logic [7:0] c, input logic last);
        string       code;
        int          owed_at_start;
        owed_at_start = owed_beats.size();
        if (!decode_mode_q) begin
            if (c == CH_SPACE) begin
                owe(CH_SLASH, 1'b0);
            end else begin
                if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
                    c = c - CASE_FOLD;
                code = morse_of(c);
                if (code.len() == 0)
                    owe(CH_ERR, 1'b1);
                for (int j = 0; j < code.len(); j++)
                    owe(code[j], 1'b0);
            end
            if (!last)
                owe(CH_SPACE, 1'b0);
        end else if (c == CH_SPACE) begin
            close_pattern();
            if (last)
                close_pattern();
        end else begin
            add_symbol(c);
            if (last)
                close_pattern();
        end
        // Mark the final beat of this run
        if (owed_beats.size() > owed_at_start)
            owed_beats[owed_beats.size() - 1].fin = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] exp_val);
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, exp_val);
        mismatch_count++;
    endtask

    // Send one input beat, with an occasional gap before it
    task automatic send_beat(input logic [7:0] c, input logic last);
        if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predict_results(c, last);
        beats_sent++;
        @(negedge aclk);
    endtask

    // Hold the input idle until every owed beat is out and the block has settled
    task automatic drain();
        s_tvalid <= 1'b0;
        while (owed_beats.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_mode(input logic mode);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge aclk);
        cfg_we        <= 1'b0;
        decode_mode_q = mode;
    endtask

    task automatic test_encode_directed();
        send_beat("z", 1'b0);       // lower case folds
        send_beat(" ", 1'b0);       // word gap becomes a slash
        send_beat("?", 1'b0);       // six symbols
        send_beat(8'hFF, 1'b0);     // no mapping
        send_beat(8'h00, 1'b1);     // no mapping, no separator
        send_beat("@", 1'b1);
    endtask

    task automatic test_decode_directed();
        send_beat(".", 1'b0);
        send_beat("-", 1'b0);
        send_beat(" ", 1'b0);
        // lone slash decodes to a space
        send_beat("/", 1'b0);
        send_beat(" ", 1'b0);
        // empty pattern
        send_beat(" ", 1'b0);
        // trailing space marked last: character then empty-pattern error
        send_beat(".", 1'b0);
        send_beat(".", 1'b0);
        send_beat(" ", 1'b1);
        // last closes without a space
        send_beat("-", 1'b1);
        // stray byte, repeated slash
        send_beat("x", 1'b1);
        send_beat("/", 1'b0);
        send_beat("/", 1'b1);
        // one symbol beyond the longest pattern
        repeat (MAX_SYMBOLS) send_beat(".", 1'b0);
        send_beat(".", 1'b1);
    endtask

    // The open pattern survives a trip through encode mode
    task automatic test_mode_switch_keeps_pattern();
        send_beat("-", 1'b0);
        send_beat(".", 1'b0);
        set_mode(1'b0);
        send_beat("E", 1'b1);
        set_mode(1'b1);
        send_beat(" ", 1'b0);
    endtask

    task automatic test_random_encode(input int count);
        logic [7:0] c;
        int         r;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 60) begin
                do c = $urandom_range(8'h5A, 8'h21); while (morse_of(c).len() == 0);
                if (c >= "A" && $urandom_range(1) == 1)
                    c = c + CASE_FOLD;
            end else if (r < 72) begin
                c = CH_SPACE;
            end else begin
                c = $urandom_range(255);
            end
            send_beat(c, $urandom_range(99) < 15);
        end
    endtask

    // Mostly well-formed words, some word gaps, some noise
    task automatic test_random_decode(input int count);
        int         start;
        int         r;
        logic [7:0] c;
        logic       close_on_symbol;
        string      code;
        start = beats_sent;
        while (beats_sent - start < count) begin
            r = $urandom_range(99);
            if (r < 70) begin
                do c = $urandom_range(8'h5A, 8'h21); while (morse_of(c).len() == 0);
                code            = morse_of(c);
                close_on_symbol = ($urandom_range(9) == 0);
                for (int j = 0; j < code.len(); j++)
                    send_beat(code[j], close_on_symbol && j == code.len() - 1);
                if (!close_on_symbol)
                    send_beat(CH_SPACE, $urandom_range(19) == 0);
            end else if (r < 80) begin
                send_beat(CH_SLASH, 1'b0);
                send_beat(CH_SPACE, 1'b0);
            end else begin
                repeat ($urandom_range(9, 1)) begin
                    case ($urandom_range(4))
                        0:       c = CH_DOT;
                        1:       c = CH_DASH;
                        2:       c = CH_SLASH;
                        3:       c = CH_SPACE;
                        default: c = $urandom_range(255);
                    endcase
                    send_beat(c, $urandom_range(9) == 0);
                end
            end
        end
    endtask

    // Result side stalls at random unless in a steady stretch
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Compare each result beat with the oldest one owed
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (owed_beats.size() == 0) begin
                report_mismatch("beat with nothing owed, out_char", m_tdata, CH_ERR);
            end else begin
                want = owed_beats.pop_front();
                if (m_tdata !== want.ch)
                    report_mismatch("out_char", m_tdata, want.ch);
                if (m_tuser !== want.err)
                    report_mismatch("error_flag", {7'd0, m_tuser}, {7'd0, want.err});
                if (m_tlast !== want.fin)
                    report_mismatch("run_end", {7'd0, m_tlast}, {7'd0, want.fin});
            end
        end
    end

    // Give up on a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 8'h00;
        s_tlast        = 1'b0;
        steady         = 1'b0;
        beats_sent     = 0;
        decode_mode_q  = 1'b0;
        pat_bits       = '0;
        pat_len        = '0;
        pat_bad        = 1'b0;
        pat_slash      = 1'b0;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        set_mode(1'b0);
        test_encode_directed();
        set_mode(1'b1);
        test_decode_directed();
        test_mode_switch_keeps_pattern();

        // Alternate modes; one decode phase runs with no idling at all
        for (int phase = 0; phase < 6; phase++) begin
            steady = (phase == 3);
            if (phase % 2 == 0) begin
                set_mode(1'b0);
                test_random_encode(40);
            end else begin
                set_mode(1'b1);
                test_random_decode(40);
            end
        end
        steady = 1'b0;

        drain();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
